// ===== sv/cdq_pkg.sv =====
package cdq_pkg;

    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic en;
        op_t  op;
    } cell_cmd_t;

    typedef struct packed {
        logic                  occ;
        logic [DATA_WIDTH-1:0] data;
    } cell_link_t;

endpackage

// ===== sv/cdq_cell.sv =====
module cdq_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cdq_pkg::cell_cmd_t                 cmd,
    input  logic [cdq_pkg::DATA_WIDTH-1:0]     push_data,
    input  cdq_pkg::cell_link_t                left,
    input  cdq_pkg::cell_link_t                right,
    output cdq_pkg::cell_link_t                self,
    output logic [cdq_pkg::DATA_WIDTH-1:0]     tail_data
);

    logic                              occ_reg;
    logic                              occ_next;
    logic [cdq_pkg::DATA_WIDTH-1:0]    data_reg;
    logic [cdq_pkg::DATA_WIDTH-1:0]    data_next;
    logic                              is_tail;

    assign is_tail   = occ_reg && !right.occ;
    assign tail_data = is_tail ? data_reg : '0;
    assign self.occ  = occ_reg;
    assign self.data = data_reg;

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                cdq_pkg::OP_PUSH_FRONT:
                begin
                    occ_next  = left.occ;
                    data_next = left.data;
                end
                cdq_pkg::OP_PUSH_BACK:
                begin
                    if (!occ_reg && left.occ)
                    begin
                        occ_next  = 1'b1;
                        data_next = push_data;
                    end
                end
                cdq_pkg::OP_POP_FRONT:
                begin
                    occ_next  = right.occ;
                    data_next = right.data;
                end
                cdq_pkg::OP_POP_BACK:
                begin
                    if (is_tail)
                    begin
                        occ_next = 1'b0;
                    end
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== sv/circular_deque_unit.sv =====
// double-ended queue of cdq_pkg::DEPTH words, kept as a row of cells in
// logical order: the front element sits in the first cell, the back element
// in the last occupied one
// input channel: in_valid / in_ready with opcode and push_value
//   push front, push back, pop front, pop back
// output channel: out_valid / out_ready with pop_value, status, is_empty and
// is_full; exactly one result beat per input beat, in order
// the result is registered: it is presented in the cycle after its input beat is taken
// throughput: one beat per cycle while the receiver keeps out_ready high; every
// cell shifts or loads in the same cycle, so no operation needs more than one step
// a push to a full queue or a pop from an empty one gives a reject status,
// a zero pop_value and leaves the contents alone
// if the receiver stalls, the result register holds and in_ready drops
// until the held beat is taken
// reset empties the queue at once (occupancy bits cleared) and drops
// out_valid; the data words are not cleared
module circular_deque_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] push_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status,
    output logic               is_empty,
    output logic               is_full
);

    localparam int D  = cdq_pkg::DEPTH;
    localparam int DW = cdq_pkg::DATA_WIDTH;

    cdq_pkg::op_t             op;
    cdq_pkg::cell_cmd_t       cmd;
    cdq_pkg::cell_link_t      left_link  [D];
    cdq_pkg::cell_link_t      right_link [D];
    cdq_pkg::cell_link_t      cell_link  [D];
    logic [DW-1:0]            tail_data  [D];
    logic [DW-1:0]            tail_or;
    logic [DW-1:0]            push_data;
    logic [D-1:0]             occ_vec;
    logic                     accept;
    logic                     is_push;
    logic                     now_empty;
    logic                     now_full;
    logic                     reject;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [31:0]       pop_value_reg;
    logic signed [31:0]       pop_value_next;
    cdq_pkg::status_t         status_reg;
    cdq_pkg::status_t         status_next;
    logic                     is_empty_reg;
    logic                     is_empty_next;
    logic                     is_full_reg;
    logic                     is_full_next;

    assign op        = cdq_pkg::op_t'(opcode);
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign push_data = DW'($unsigned(push_value));
    assign is_push   = (op == cdq_pkg::OP_PUSH_FRONT) || (op == cdq_pkg::OP_PUSH_BACK);
    assign now_empty = !occ_vec[0];
    assign now_full  = occ_vec[D-1];
    assign reject    = is_push ? now_full : now_empty;
    assign cmd.en    = accept && !reject;
    assign cmd.op    = op;

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_link[g].occ  = 1'b1;
                assign left_link[g].data = push_data;
            end
            else
            begin : g_mid
                assign left_link[g] = cell_link[g-1];
            end

            if (g == D - 1)
            begin : g_last
                assign right_link[g].occ  = 1'b0;
                assign right_link[g].data = '0;
            end
            else
            begin : g_inner
                assign right_link[g] = cell_link[g+1];
            end

            assign occ_vec[g] = cell_link[g].occ;

            cdq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .push_data (push_data),
                .left      (left_link[g]),
                .right     (right_link[g]),
                .self      (cell_link[g]),
                .tail_data (tail_data[g])
            );
        end
    endgenerate

    // back element: exactly one cell flags itself as tail when not empty
    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < D; i++)
        begin
            tail_or = tail_or | tail_data[i];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        is_empty_next  = is_empty_reg;
        is_full_next   = is_full_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            pop_value_next = '0;
            if (is_push)
            begin
                status_next   = now_full ? cdq_pkg::ST_FULL : cdq_pkg::ST_OK;
                is_empty_next = 1'b0;
                is_full_next  = occ_vec[D-2];
            end
            else
            begin
                status_next   = now_empty ? cdq_pkg::ST_EMPTY : cdq_pkg::ST_OK;
                is_empty_next = !occ_vec[1];
                is_full_next  = 1'b0;
                if (!now_empty)
                begin
                    if (op == cdq_pkg::OP_POP_FRONT)
                    begin
                        pop_value_next = 32'($unsigned(cell_link[0].data));
                    end
                    else
                    begin
                        pop_value_next = 32'($unsigned(tail_or));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
        is_empty_reg  <= is_empty_next;
        is_full_reg   <= is_full_next;
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

    // occupied cells stay packed towards the front
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_vec & ~{occ_vec[D-2:0], 1'b1}) == '0)
        else $error("gap in occupied cells");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_push && now_full |=> out_valid && status_reg == cdq_pkg::ST_FULL
            && is_full_reg && $stable(occ_vec))
        else $error("push to full queue not rejected cleanly");

    a_pop_front: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == cdq_pkg::OP_POP_FRONT && !now_empty
            |=> pop_value_reg == 32'($unsigned($past(cell_link[0].data))))
        else $error("pop front returned wrong word");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(is_empty_reg && is_full_reg))
        else $error("empty and full both set");

endmodule
